FILE: hdl/wrps_pkg.sv
// ----------------------------------------------------------------------------
// wrps_pkg: shared types and constants
// Widths, controller state encoding and the command/status bundles that
// join the controller and the datapath of the weighted path selector.
// ----------------------------------------------------------------------------
package wrps_pkg;

  localparam int MAX_PATHS    = 16;
  localparam int WEIGHT_SCALE = 1000;

  localparam int IDX_W   = $clog2(MAX_PATHS);
  localparam int CNT_W   = 5;                 // path_count register width
  localparam int PORT_W  = 16;
  localparam int RTT_W   = 16;
  localparam int LOSS_W  = 17;
  localparam int DRAW_W  = 16;
  localparam int W_W     = 10;
  localparam int TOT_W   = W_W + IDX_W;       // sum of all weights
  localparam int NUM_W   = LOSS_W + W_W;      // WEIGHT_SCALE * (1 - loss)
  localparam int DEN_W   = RTT_W + 1;         // rtt + 1
  localparam int DCNT_W  = $clog2(W_W);
  localparam int PROD_W  = DRAW_W + TOT_W;

  localparam logic [LOSS_W-1:0] ONE_Q16    = LOSS_W'(65536);
  localparam logic [W_W-1:0]    RESET_W    = W_W'(WEIGHT_SCALE / 51);
  localparam logic [CNT_W-1:0]  MAX_CNT    = CNT_W'(MAX_PATHS);
  localparam logic [DCNT_W-1:0] DIV_LAST   = DCNT_W'(W_W - 1);

  localparam logic OP_UPDATE = 1'b0;
  localparam logic OP_SELECT = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UPD_MUL,
    ST_UPD_DIV,
    ST_UPD_FIN,
    ST_SEL_EMPTY,
    ST_SEL_SUM,
    ST_SEL_SCALE,
    ST_SEL_WALK
  } state_t;

  typedef struct packed {
    logic load;       // capture input beat, clear accumulators
    logic mul;        // scale (1 - loss), seed divider
    logic div_step;   // one quotient bit
    logic upd_fin;    // write table, post update result
    logic sel_empty;  // post no-paths result
    logic sum_step;   // add one weight into total
    logic scale;      // r = ((draw * total) >> 16) + 1
    logic walk_step;  // add one weight into running sum, test against r
  } cmd_t;

  typedef struct packed {
    logic n_zero;
    logic div_last;
    logic sum_last;
    logic walk_done;
  } sts_t;

endpackage

FILE: hdl/wrps_ctrl.sv
// ----------------------------------------------------------------------------
// wrps_ctrl: sequencing controller
// Steps the datapath through the update (multiply, divide, write) and the
// select (sum, scale, walk) sequences.
// ----------------------------------------------------------------------------
module wrps_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic          in_op,
  input  wrps_pkg::sts_t sts,
  output wrps_pkg::cmd_t cmd,
  output logic          busy
);
  import wrps_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          if (in_op == OP_UPDATE) state_nxt = ST_UPD_MUL;
          else if (sts.n_zero)    state_nxt = ST_SEL_EMPTY;
          else                    state_nxt = ST_SEL_SUM;
        end
      end
      ST_UPD_MUL:   state_nxt = ST_UPD_DIV;
      ST_UPD_DIV:   if (sts.div_last) state_nxt = ST_UPD_FIN;
      ST_UPD_FIN:   state_nxt = ST_IDLE;
      ST_SEL_EMPTY: state_nxt = ST_IDLE;
      ST_SEL_SUM:   if (sts.sum_last) state_nxt = ST_SEL_SCALE;
      ST_SEL_SCALE: state_nxt = ST_SEL_WALK;
      ST_SEL_WALK:  if (sts.walk_done) state_nxt = ST_IDLE;
      default:      state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    case (state_r)
      ST_IDLE: begin
        busy     = 1'b0;
        cmd.load = start;
      end
      ST_UPD_MUL:   cmd.mul       = 1'b1;
      ST_UPD_DIV:   cmd.div_step  = 1'b1;
      ST_UPD_FIN:   cmd.upd_fin   = 1'b1;
      ST_SEL_EMPTY: cmd.sel_empty = 1'b1;
      ST_SEL_SUM:   cmd.sum_step  = 1'b1;
      ST_SEL_SCALE: cmd.scale     = 1'b1;
      ST_SEL_WALK:  cmd.walk_step = 1'b1;
      default:      busy          = 1'b1;
    endcase
  end

endmodule

FILE: hdl/wrps_dp.sv
// ----------------------------------------------------------------------------
// wrps_dp: selector datapath
// Path tables, path_count register, weight multiplier and radix-2 divider,
// weight accumulator, draw scaler and the result registers.
// ----------------------------------------------------------------------------
module wrps_dp (
  input  logic                           clk,
  input  logic                           rst_n,
  input  wrps_pkg::cmd_t                 cmd,
  output wrps_pkg::sts_t                 sts,
  input  logic                           cfg_we,
  input  logic [wrps_pkg::CNT_W-1:0]     cfg_data,
  input  logic                           in_op,
  input  logic [wrps_pkg::IDX_W-1:0]     in_path_index,
  input  logic [wrps_pkg::PORT_W-1:0]    in_port,
  input  logic [wrps_pkg::RTT_W-1:0]     in_rtt_ms,
  input  logic [wrps_pkg::LOSS_W-1:0]    in_loss_fraction,
  input  logic [wrps_pkg::DRAW_W-1:0]    in_rand_draw,
  output logic                           out_valid,
  output logic                           out_kind,
  output logic [wrps_pkg::IDX_W-1:0]     out_chosen_index,
  output logic [wrps_pkg::PORT_W-1:0]    out_chosen_port,
  output logic [wrps_pkg::W_W-1:0]       out_path_weight,
  output logic                           out_no_paths
);
  import wrps_pkg::*;

  logic [CNT_W-1:0]  path_count_r;
  logic [PORT_W-1:0] port_tab_r   [MAX_PATHS];
  logic [W_W-1:0]    weight_tab_r [MAX_PATHS];

  // captured beat
  logic              op_r;
  logic [IDX_W-1:0]  idx_r;
  logic [PORT_W-1:0] port_r;
  logic [DEN_W-1:0]  den_r;
  logic [LOSS_W-1:0] loss_r;
  logic [DRAW_W-1:0] draw_r;

  // divider
  logic [W_W-1:0]    quo_r;
  logic [DEN_W-1:0]  rem_r;
  logic [DCNT_W-1:0] dcnt_r;

  // select walk
  logic [IDX_W-1:0]  cnt_r;
  logic [TOT_W-1:0]  total_r;
  logic [TOT_W-1:0]  run_r;
  logic [TOT_W-1:0]  thr_r;

  logic              out_valid_r;
  logic              out_kind_r;
  logic [IDX_W-1:0]  out_idx_r;
  logic [PORT_W-1:0] out_port_r;
  logic [W_W-1:0]    out_w_r;
  logic              out_np_r;

  logic [CNT_W-1:0]  n_eff;
  logic              cnt_last;
  logic [W_W-1:0]    w_cur;
  logic [PORT_W-1:0] port_cur;
  logic [LOSS_W-1:0] loss_clamp;
  logic [NUM_W-1:0]  num_prod;
  logic [DEN_W:0]    rem_sh;
  logic              q_bit;
  logic [DEN_W:0]    rem_sub;
  logic [W_W-1:0]    w_new;
  logic [TOT_W-1:0]  run_nxt;
  logic              hit;
  logic [PROD_W-1:0] draw_prod;

  assign n_eff    = (path_count_r > MAX_CNT) ? MAX_CNT : path_count_r;
  assign cnt_last = (CNT_W'(cnt_r) + CNT_W'(1)) == n_eff;
  assign w_cur    = weight_tab_r[cnt_r];
  assign port_cur = port_tab_r[cnt_r];

  // floor(S*(1-L)/((rtt+1)*2^16)) == floor(floor(S*(1-L)/2^16)/(rtt+1))
  assign loss_clamp = (loss_r > ONE_Q16) ? ONE_Q16 : loss_r;
  assign num_prod   = NUM_W'(ONE_Q16 - loss_clamp) * NUM_W'(WEIGHT_SCALE);

  assign rem_sh  = {rem_r, quo_r[W_W-1]};
  assign q_bit   = rem_sh >= {1'b0, den_r};
  assign rem_sub = rem_sh - {1'b0, den_r};
  assign w_new   = (quo_r == '0) ? W_W'(1) : quo_r;

  assign run_nxt   = run_r + TOT_W'(w_cur);
  assign hit       = thr_r <= run_nxt;
  assign draw_prod = PROD_W'(draw_r) * PROD_W'(total_r);

  assign sts.n_zero    = (n_eff == '0);
  assign sts.div_last  = (dcnt_r == DIV_LAST);
  assign sts.sum_last  = cnt_last;
  assign sts.walk_done = hit || cnt_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      path_count_r <= '0;
    end else if (cfg_we) begin
      path_count_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAX_PATHS; i++) begin
        port_tab_r[i]   <= '0;
        weight_tab_r[i] <= RESET_W;
      end
    end else if (cmd.upd_fin) begin
      port_tab_r[idx_r]   <= port_r;
      weight_tab_r[idx_r] <= w_new;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r    <= in_op;
      idx_r   <= in_path_index;
      port_r  <= in_port;
      den_r   <= DEN_W'(in_rtt_ms) + DEN_W'(1);
      loss_r  <= in_loss_fraction;
      draw_r  <= in_rand_draw;
      cnt_r   <= '0;
      total_r <= '0;
      run_r   <= '0;
    end
    if (cmd.mul) begin
      // drop the 16 fraction bits; the integer part is at most WEIGHT_SCALE
      quo_r  <= num_prod[LOSS_W-1 +: W_W];
      rem_r  <= '0;
      dcnt_r <= '0;
    end
    if (cmd.div_step) begin
      rem_r  <= q_bit ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
      quo_r  <= {quo_r[W_W-2:0], q_bit};
      dcnt_r <= dcnt_r + DCNT_W'(1);
    end
    if (cmd.sum_step) begin
      total_r <= total_r + TOT_W'(w_cur);
      cnt_r   <= cnt_last ? '0 : cnt_r + IDX_W'(1);
    end
    if (cmd.scale) begin
      thr_r <= draw_prod[PROD_W-1 -: TOT_W] + TOT_W'(1);
    end
    if (cmd.walk_step) begin
      run_r <= run_nxt;
      cnt_r <= cnt_r + IDX_W'(1);
    end
  end

  // result beat: one-cycle strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.upd_fin || cmd.sel_empty || (cmd.walk_step && sts.walk_done);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.upd_fin) begin
      out_kind_r <= OP_UPDATE;
      out_idx_r  <= idx_r;
      out_port_r <= port_r;
      out_w_r    <= w_new;
      out_np_r   <= 1'b0;
    end else if (cmd.sel_empty) begin
      out_kind_r <= OP_SELECT;
      out_idx_r  <= '0;
      out_port_r <= '0;
      out_w_r    <= '0;
      out_np_r   <= 1'b1;
    end else if (cmd.walk_step && sts.walk_done) begin
      out_kind_r <= op_r;
      out_idx_r  <= cnt_r;
      out_port_r <= port_cur;
      out_w_r    <= w_cur;
      out_np_r   <= 1'b0;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_kind         = out_kind_r;
  assign out_chosen_index = out_idx_r;
  assign out_chosen_port  = out_port_r;
  assign out_path_weight  = out_w_r;
  assign out_no_paths     = out_np_r;

endmodule

FILE: hdl/weighted_random_path_selector_unit.sv
// ----------------------------------------------------------------------------
// weighted_random_path_selector_unit: weighted random path choice
// Keeps per-path port and weight; updates weights from rtt/loss and picks
// a path for a random draw in proportion to the weights.
// ----------------------------------------------------------------------------
// Usage:
//   Input beat: raise start with the in_* fields; it is taken on a clock
//   edge where busy is low. busy stays high until the result is posted.
//   Result beat: out_valid is high for one cycle with out_* fields; the
//   receiver must take it then, there is no backpressure.
//   cfg_valid/cfg_data write path_count (cfg_ready is always high); write
//   it only while the block is idle.
//   Sequence, start accept to out_valid:
//     update: multiply, 10 divider steps, table write
//     select, no paths in use: no-paths result, no table sweep
//     select: sum over the n paths in use, draw scaling, then k = 1..n
//     walk steps; the two table sweeps take the most time.
//   A new start is taken the cycle the result is shown.
//   Reset: path_count 0, all ports 0, all weights 19.
// ----------------------------------------------------------------------------
module weighted_random_path_selector_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic                           in_op,
  input  logic [wrps_pkg::IDX_W-1:0]     in_path_index,
  input  logic [wrps_pkg::PORT_W-1:0]    in_port,
  input  logic [wrps_pkg::RTT_W-1:0]     in_rtt_ms,
  input  logic [wrps_pkg::LOSS_W-1:0]    in_loss_fraction,
  input  logic [wrps_pkg::DRAW_W-1:0]    in_rand_draw,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [wrps_pkg::CNT_W-1:0]     cfg_data,
  output logic                           out_valid,
  output logic                           out_kind,
  output logic [wrps_pkg::IDX_W-1:0]     out_chosen_index,
  output logic [wrps_pkg::PORT_W-1:0]    out_chosen_port,
  output logic [wrps_pkg::W_W-1:0]       out_path_weight,
  output logic                           out_no_paths
);
  import wrps_pkg::*;

  cmd_t cmd;
  sts_t sts;
  logic start_ok;

  assign cfg_ready = 1'b1;
  assign start_ok  = start && !busy;

  wrps_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start_ok),
    .in_op (in_op),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy)
  );

  wrps_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .cfg_we           (cfg_valid && cfg_ready),
    .cfg_data         (cfg_data),
    .in_op            (in_op),
    .in_path_index    (in_path_index),
    .in_port          (in_port),
    .in_rtt_ms        (in_rtt_ms),
    .in_loss_fraction (in_loss_fraction),
    .in_rand_draw     (in_rand_draw),
    .out_valid        (out_valid),
    .out_kind         (out_kind),
    .out_chosen_index (out_chosen_index),
    .out_chosen_port  (out_chosen_port),
    .out_path_weight  (out_path_weight),
    .out_no_paths     (out_no_paths)
  );

`ifndef SYNTHESIS
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start_ok |=> busy) else $error("busy not raised after accepted beat");
  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result strobe longer than one cycle");
  a_nopaths_kind: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_no_paths) |-> out_kind) else $error("no_paths on update result");
  a_weight_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_no_paths) |-> (out_path_weight != '0))
    else $error("zero weight in result");
`endif

endmodule
